// File: rtl/core/divisor_count_trial_division_assert.svh
// Assertion macros shared by the divisor count checker.
// Each macro states one clocked property that is gated off while reset is low.
`ifndef DIVISOR_COUNT_TRIAL_DIVISION_ASSERT_SVH
`define DIVISOR_COUNT_TRIAL_DIVISION_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define DCTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define DCTD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/dctd_pkg.sv
// ----------------------------------------------------------------------------
// dctd_pkg
// Shared types and constants for the divisor count block: controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dctd_pkg;

  // Width and ceiling of the divisor count
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // First odd trial factor and the step between trial factors
  localparam int unsigned TRIAL_START = 3;
  localparam int unsigned TRIAL_STEP  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_REDUCE,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic shift_two;
    logic e_inc;
    logic e_clr;
    logic f_init;
    logic f_step;
    logic take_quot;
    logic mul_count;
    logic mul_two;
    logic clr_count;
    logic div_start;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic n_even;
    logic n_is_one;
    logic div_busy;
    logic f_gt_q;
    logic r_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/dctd_div.sv
// ----------------------------------------------------------------------------
// dctd_div
// Restoring radix-2 divider: one quotient bit per cycle across the VALUE_WIDTH
// dividend bits. Quotient and remainder stay registered until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dctd_div #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FACTOR_W    = 18
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [FACTOR_W-1:0]    divisor_i,
  output logic                        busy_o,
  output logic [VALUE_WIDTH-1:0]      quot_o,
  output logic [FACTOR_W-1:0]         rem_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [FACTOR_W-1:0]    rem_q, rem_d;
  logic [FACTOR_W:0]      rem_shift;
  logic [FACTOR_W:0]      rem_diff;
  logic                   fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign rem_shift = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_i};
  assign fits      = rem_shift >= {1'b0, divisor_i};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(VALUE_WIDTH);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? rem_diff[FACTOR_W-1:0] : rem_shift[FACTOR_W-1:0];
    end
  end

  // Step counter is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/dctd_datapath.sv
// ----------------------------------------------------------------------------
// dctd_datapath
// Working registers for the cofactor, trial factor, exponent and count, the
// saturating count multiplier, the shared divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dctd_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire dctd_pkg::cmd_t               cmd_i,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  input  wire logic                         out_ready_i,
  output dctd_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  output logic [dctd_pkg::COUNT_W-1:0]      divisor_count_o
);

  import dctd_pkg::*;

  localparam int unsigned FACTOR_W = VALUE_WIDTH / 2 + 2;
  localparam int unsigned EXP_W    = $clog2(VALUE_WIDTH + 2);
  localparam int unsigned PROD_W   = COUNT_W + EXP_W;

  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [EXP_W-1:0]       e_q, e_d;
  logic [FACTOR_W-1:0]    f_q, f_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]     out_count_q;

  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] quot;
  logic [FACTOR_W-1:0]    rem;

  logic [EXP_W-1:0]       mul_op;
  logic [PROD_W-1:0]      prod;
  logic [COUNT_W-1:0]     prod_sat;

  // Multiply the count by the exponent plus one, or by two, and saturate
  assign mul_op   = cmd_i.mul_two ? EXP_W'(2) : e_q;
  assign prod     = PROD_W'(count_q) * PROD_W'(mul_op);
  assign prod_sat = (prod > {{EXP_W{1'b0}}, COUNT_MAX}) ? COUNT_MAX : prod[COUNT_W-1:0];

  // Next values of the working registers
  always_comb begin
    n_d = n_q;
    if (cmd_i.load) begin
      n_d = value_i;
    end else if (cmd_i.shift_two) begin
      n_d = n_q >> 1;
    end else if (cmd_i.take_quot) begin
      n_d = quot;
    end

    e_d = e_q;
    if (cmd_i.load || cmd_i.e_clr) begin
      e_d = EXP_W'(1);
    end else if (cmd_i.e_inc || cmd_i.shift_two) begin
      e_d = e_q + EXP_W'(1);
    end

    f_d = f_q;
    if (cmd_i.f_init) begin
      f_d = FACTOR_W'(TRIAL_START);
    end else if (cmd_i.f_step) begin
      f_d = f_q + FACTOR_W'(TRIAL_STEP);
    end

    count_d = count_q;
    if (cmd_i.load) begin
      count_d = COUNT_W'(1);
    end else if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.mul_count) begin
      count_d = prod_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    e_q     <= e_d;
    f_q     <= f_d;
    count_q <= count_d;
  end

  // Shared divider: cofactor over trial factor, loaded with the next cofactor
  dctd_div #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FACTOR_W    (FACTOR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_d),
    .divisor_i  (f_d),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Output word register: hold until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= count_q;
    end
  end

  // Status back to the controller
  assign sts_o.n_zero   = n_q == '0;
  assign sts_o.n_even   = !n_q[0];
  assign sts_o.n_is_one = n_q == VALUE_WIDTH'(1);
  assign sts_o.div_busy = div_busy;
  assign sts_o.f_gt_q   = {{(VALUE_WIDTH - FACTOR_W){1'b0}}, f_q} > quot;
  assign sts_o.r_zero   = rem == '0;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign divisor_count_o = out_count_q;

endmodule

`default_nettype wire

// File: rtl/core/dctd_ctrl.sv
// ----------------------------------------------------------------------------
// dctd_ctrl
// Sequencer for the divisor count: strip factors of two, walk odd trial
// factors through the divider, fold in a leftover prime, hand off the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dctd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire dctd_pkg::sts_t sts_i,
  output dctd_pkg::cmd_t      cmd_o,
  output logic                in_ready_o
);

  import dctd_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.n_zero) begin
          state_d = ST_OUT;
        end else if (!sts_i.n_even) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!sts_i.div_busy) begin
          if (sts_i.f_gt_q) begin
            state_d = ST_FINISH;
          end else if (sts_i.r_zero) begin
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (!sts_i.div_busy && !sts_i.r_zero) begin
          state_d = ST_TEST;
        end
      end
      ST_FINISH: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        if (sts_i.n_zero) begin
          cmd_o.clr_count = 1'b1;
        end else if (sts_i.n_even) begin
          cmd_o.shift_two = 1'b1;
        end else begin
          cmd_o.mul_count = 1'b1;
          cmd_o.e_clr     = 1'b1;
          cmd_o.f_init    = 1'b1;
          cmd_o.div_start = 1'b1;
        end
      end
      ST_TEST, ST_REDUCE: begin
        if (!sts_i.div_busy && !(state_q == ST_TEST && sts_i.f_gt_q)) begin
          if (sts_i.r_zero) begin
            // Factor divides: count it and divide the quotient again
            cmd_o.e_inc     = 1'b1;
            cmd_o.take_quot = 1'b1;
            cmd_o.div_start = 1'b1;
          end else begin
            // Factor exhausted: fold exponent in and advance to next odd factor
            cmd_o.mul_count = 1'b1;
            cmd_o.e_clr     = 1'b1;
            cmd_o.f_step    = 1'b1;
            cmd_o.div_start = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!sts_i.n_is_one) begin
          cmd_o.mul_count = 1'b1;
          cmd_o.mul_two   = 1'b1;
        end
      end
      ST_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/divisor_count_trial_division.sv
// A nonzero word takes one shift per factor of two, then its divisions: one per odd
// trial factor tried, the first past the square root included, plus one per odd
// prime factor removed (with multiplicity). Zero goes straight to the output.
// All divisions run on the single shared divider, one quotient bit per cycle.
// Throughput: one word at a time; the next word is taken once the result is
// in the output register. Reset clears controller, divider and output valid.
// ----------------------------------------------------------------------------
// divisor_count_trial_division
// Counts the positive divisors of an unsigned integer by trial division with
// an iterative divider; zero gives a count of zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module divisor_count_trial_division #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [dctd_pkg::COUNT_W-1:0]      divisor_count_o
);

  import dctd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  dctd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // Datapath
  dctd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .out_ready_i     (out_ready_i),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .divisor_count_o (divisor_count_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/dctd_checker.sv
// ----------------------------------------------------------------------------
// dctd_checker
// Port-level checks for the divisor count block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "divisor_count_trial_division_assert.svh"

module dctd_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0]       value_i,
  input  wire logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire logic [dctd_pkg::COUNT_W-1:0] divisor_count_o
);

  // Handshake conditions seen at the ports
  logic in_take;
  logic in_wait;
  logic out_stall;

  assign in_take   = in_valid_i && in_ready_o;
  assign in_wait   = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // Hold a waiting input word
  `DCTD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(value_i))

  // Hold a stalled output word
  `DCTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(divisor_count_o))

  // Drop ready right after taking a word
  `DCTD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_take, !in_ready_o)

  // A new result coincides with the return to idle
  `DCTD_ASSERT_SAME(a_result_then_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

endmodule

bind divisor_count_trial_division dctd_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_dctd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .value_i         (value_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .divisor_count_o (divisor_count_o)
);

`default_nettype wire

// File: bench/divisor_count_trial_division_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_count_trial_division_tb
// Sends unsigned words to the divisor count block and compares each returned
// count with a trial-division predictor kept in the bench. A directed set of
// edge values is followed by random words that are cheap enough to keep the
// run short. Both channels idle at random, and one phase holds the output
// long enough to stall the input.
// ----------------------------------------------------------------------------

module divisor_count_trial_division_tb;
  import dctd_pkg::*;

  localparam int unsigned VW = 32;
  // Random full-width words above this many trial divisions are redrawn
  localparam int unsigned RUN_BUDGET = 150;
  localparam int unsigned LONG_HOLD = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic [VW-1:0]       value_i = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [COUNT_W-1:0]  divisor_count_o;

  logic [COUNT_W-1:0]  pending_counts[$];
  logic [COUNT_W-1:0]  expected_count;
  int unsigned         error_count = 0;
  int unsigned         words_sent = 0;
  int unsigned         directed_words = 0;
  int unsigned         counts_checked = 0;
  int unsigned         top_count = 0;
  int unsigned         top_runs = 0;
  int unsigned         burst_left = 0;

  // Receiver pattern and long hold requests
  int unsigned         hold_requests = 0;
  int unsigned         hold_served = 0;
  int unsigned         hold_left = 0;
  int unsigned         mode_left = 0;
  int unsigned         ready_mode = 0;
  int unsigned         ready_phase = 0;

  divisor_count_trial_division #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .divisor_count_o (divisor_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Count divisors by trial division; also report how many remainders it took
  function automatic logic [COUNT_W-1:0] count_divisors(input logic [VW-1:0] word,
                                                         output int unsigned div_runs);
    logic [VW-1:0] n;
    logic [VW-1:0] f;
    int unsigned   e;
    int unsigned   cnt;
    n = word;
    div_runs = 0;
    if (n == '0) return '0;
    // strip factors of two
    e = 1;
    while (!n[0]) begin
      e++;
      n = n >> 1;
    end
    cnt = e;
    // odd trial factors while f * f <= n
    f = TRIAL_START;
    while (f <= n / f) begin
      e = 1;
      div_runs++;
      while (n % f == 0) begin
        e++;
        n = n / f;
        div_runs++;
      end
      cnt = cnt * e;
      if (cnt > COUNT_MAX) cnt = COUNT_MAX;
      f = f + TRIAL_STEP;
    end
    // leftover prime doubles the count
    if (n != 1) begin
      cnt = cnt * 2;
      if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    end
    return cnt[COUNT_W-1:0];
  endfunction

  // Draw a random word whose trial division stays short
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    int unsigned   runs;
    int unsigned   p;
    int unsigned   tries;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom_range(0, 4095);
      3, 4, 5: v = $urandom_range(1, 65535) << $urandom_range(0, 31);
      6, 7: begin
        // product of small primes: high counts, short search
        v = 32'd1 << $urandom_range(0, 6);
        repeat ($urandom_range(2, 12)) begin
          case ($urandom_range(0, 7))
            0: p = 3;
            1: p = 5;
            2: p = 7;
            3: p = 11;
            4: p = 13;
            5: p = 17;
            6: p = 19;
            default: p = 23;
          endcase
          if (v <= 32'hFFFF_FFFF / p) v = v * p;
        end
      end
      default: begin
        // full-width word, redrawn until the search is short
        tries = 0;
        v = $urandom;
        void'(count_divisors(v, runs));
        while (runs > RUN_BUDGET && tries < 16) begin
          v = $urandom;
          void'(count_divisors(v, runs));
          tries++;
        end
        if (runs > RUN_BUDGET) v = v >> 20;
      end
    endcase
    return v;
  endfunction

  // Offer one word in bursts with random gaps; queue its count on acceptance
  task automatic send_word(input logic [VW-1:0] word);
    int unsigned  gap;
    int unsigned  runs;
    logic [COUNT_W-1:0] cnt;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    value_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    cnt = count_divisors(word, runs);
    pending_counts.insert(pending_counts.size(), cnt);
    words_sent++;
    if (cnt > top_count) top_count = cnt;
    if (runs > top_runs) top_runs = runs;
  endtask

  // Edge values, prime powers, smooth and wide words
  task automatic test_directed_values();
    logic [VW-1:0] words[$];
    words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd25,
              32'd49, 32'd97, 32'd729, 32'd1023, 32'd1024, 32'd30030, 32'd63001,
              32'd65537, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_0000,
              32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd3491888400};
    foreach (words[i]) send_word(words[i]);
    directed_words = words.size();
  endtask

  task automatic test_random_values(input int unsigned n_words);
    repeat (n_words) send_word(pick_value());
  endtask

  // Hold the output while words keep coming so the input backs up
  task automatic test_output_backpressure();
    hold_requests++;
    send_word(32'd12);
    send_word(32'd360);
    send_word(32'd5040);
    send_word(32'd97);
    send_word(32'd0);
    send_word(32'd1);
  endtask

  // Check each word taken from the output, then set ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_counts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected count: expected none, actual %0d",
                   $time, divisor_count_o);
        end else begin
          expected_count = pending_counts.pop_front();
          counts_checked++;
          if (divisor_count_o !== expected_count) begin
            error_count++;
            $display("%0t: divisor_count mismatch: expected %0d, actual %0d",
                     $time, expected_count, divisor_count_o);
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      ready_phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 96);
          ready_mode = $urandom_range(0, 3);
        end
        mode_left--;
        case (ready_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (ready_phase % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_output_backpressure();
    test_random_values(70);

    // drop valid and drain the remaining counts
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d words (%0d directed), checked %0d counts, including a long",
             words_sent, directed_words, counts_checked);
    $display("output hold; largest count %0d, longest search %0d trial divisions",
             top_count, top_runs);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("%0t: timed out with %0d counts outstanding", $time, pending_counts.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dctd_pkg.sv
rtl/core/dctd_div.sv
rtl/core/dctd_datapath.sv
rtl/core/dctd_ctrl.sv
rtl/core/divisor_count_trial_division.sv
rtl/core/dctd_checker.sv
bench/divisor_count_trial_division_tb.sv
